>>> rtl/core/tagged_start_stop_latency_monitor_macros.svh
// Assertion macros shared by the monitor RTL.
`ifndef TAGGED_START_STOP_LATENCY_MONITOR_MACROS_SVH
`define TAGGED_START_STOP_LATENCY_MONITOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define TSSLM_CHECK_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsslm check failed");

// Check a consequent in the cycle after its antecedent.
`define TSSLM_CHECK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsslm check failed");

`endif

>>> rtl/core/tsslm_pkg.sv
`timescale 1ns / 1ps
package tsslm_pkg;

  localparam int TS_W       = 64;
  localparam int GRP_W      = 32;
  localparam int TAG_W      = 32;
  localparam int CPU_W      = 12;
  localparam int CNT_W      = 64;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 400;
  localparam int IN_PAD_W   = IN_DATA_W - (TS_W + GRP_W + TAG_W + CPU_W + 2);
  localparam int OUT_PAD_W  = OUT_DATA_W - (3 * TS_W + 2 * CNT_W + GRP_W + TAG_W + CPU_W);

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED   = 3'd0,
    ST_STORED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_SWITCH = 3'd3,
    ST_MISSING   = 3'd4,
    ST_NEGATIVE  = 3'd5,
    ST_SINK_FULL = 3'd6,
    ST_SAMPLE    = 3'd7
  } status_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic                sink_ready;
    logic [CPU_W-1:0]    cpu_id;
    logic                switch_mark;
    logic [TAG_W-1:0]    thread_tag;
    logic [GRP_W-1:0]    group_id;
    logic [TS_W-1:0]     timestamp;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [CNT_W-1:0]     class_count;
    logic [CNT_W-1:0]     status_count;
    logic [CPU_W-1:0]     sample_cpu;
    logic [TAG_W-1:0]     sample_thread;
    logic [GRP_W-1:0]     sample_group;
    logic [TS_W-1:0]      latency;
    logic [TS_W-1:0]      end_time;
    logic [TS_W-1:0]      start_time;
  } out_beat_t;

  typedef struct packed {
    logic            sub;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic            carry;
    logic [CNT_W-1:0] sum;
  } alu_rsp_t;

endpackage

>>> rtl/core/tsslm_alu.sv
`timescale 1ns / 1ps
module tsslm_alu (
  input  tsslm_pkg::alu_req_t req,
  output tsslm_pkg::alu_rsp_t rsp
);
  import tsslm_pkg::*;

  logic [CNT_W:0] total;

  // add, or subtract by two's complement; carry clear means borrow
  assign total = {1'b0, req.a} + {1'b0, req.b ^ {CNT_W{req.sub}}} + {{CNT_W{1'b0}}, req.sub};
  assign rsp.carry = total[CNT_W];
  assign rsp.sum   = total[CNT_W-1:0];

endmodule

>>> rtl/core/tagged_start_stop_latency_monitor.sv
`timescale 1ns / 1ps
// An ignored beat goes straight to the output stage; a tracked start, or a tracked end
// with its switch mark, runs a linear tag search that reads one table entry per cycle
// through the single memory read port. The block takes no beat while one is in work.
// Reset (rst_n low, synchronous) clears all valid bits, the event counters and the
// sequencer, config and output-valid registers at once; no clearing pass follows.
`include "tagged_start_stop_latency_monitor_macros.svh"
module tagged_start_stop_latency_monitor #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tuser: operation
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata: timestamp, group_id, thread_tag, switch_mark, cpu_id, sink_ready
  input  logic [tsslm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  // out_tuser: status
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: start_time, end_time, latency, sample_group, sample_thread,
  //            sample_cpu, status_count, class_count
  output logic [tsslm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [tsslm_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import tsslm_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] LAST_ADDR = CW'(TABLE_DEPTH);
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_EVAL    = 6'b000100,
    S_CNT_CLS = 6'b001000,
    S_CNT_STS = 6'b010000,
    S_OUT     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic             enable_r;
  logic [GRP_W-1:0] target_r;

  in_beat_t in_beat;
  logic     in_acc;
  logic     cfg_wr;
  logic     ignore;

  logic             op_r;
  logic [TS_W-1:0]  ts_r;
  logic [GRP_W-1:0] grp_r;
  logic [TAG_W-1:0] tag_r;
  logic [CPU_W-1:0] cpu_r;
  logic             rdy_r;
  status_t          status_r;

  logic [TAG_W+TS_W-1:0] mem [TABLE_DEPTH];
  logic [TAG_W+TS_W-1:0] rd_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  logic [CW-1:0] addr_r;
  logic          q_live_r;
  logic          q_vld_r;
  logic [IW-1:0] q_idx_r;
  logic          found_r;
  logic [IW-1:0] hit_idx_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  logic          issue;
  logic          hit_now;
  logic          scan_miss;

  logic          wr_en;
  logic [IW-1:0] wr_idx;

  logic [CNT_W-1:0] cnt_r [8];
  logic [2:0]       cnt_idx;
  logic [CNT_W-1:0] ccnt_r;
  logic [CNT_W-1:0] scnt_r;
  logic [TS_W-1:0]  lat_r;
  logic [TS_W-1:0]  start_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic      out_valid_r;
  out_beat_t out_r;
  status_t   out_status_r;
  out_beat_t out_nxt;
  logic      out_load;
  logic      is_sample;

  assign in_beat   = in_tdata;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ignore    = !enable_r || (in_beat.group_id != target_r);

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      target_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ENABLE: enable_r <= cfg_pwdata[0];
        REG_TARGET: target_r <= cfg_pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ENABLE: cfg_prdata = {31'b0, enable_r};
      REG_TARGET: cfg_prdata = target_r;
      default:    cfg_prdata = '0;
    endcase
  end

  // search control
  assign hit_now   = q_live_r && q_vld_r && (rd_r[TAG_W+TS_W-1:TS_W] == tag_r);
  assign issue     = (state_r == S_SCAN) && (addr_r != LAST_ADDR) && !hit_now;
  assign scan_miss = (addr_r == LAST_ADDR) && !hit_now;

  // shared adder: subtract in eval, increment in the count states
  assign cnt_idx = (state_r == S_CNT_CLS) ? {2'b00, op_r} : status_r;

  always_comb begin
    if (state_r == S_EVAL) begin
      alu_req.sub = 1'b1;
      alu_req.a   = ts_r;
      alu_req.b   = rd_r[TS_W-1:0];
    end else begin
      alu_req.sub = 1'b0;
      alu_req.a   = cnt_r[cnt_idx];
      alu_req.b   = {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  tsslm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // table write
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = hit_idx_r;
    if ((state_r == S_EVAL) && (op_r == OP_START)) begin
      if (found_r) begin
        wr_en = 1'b1;
      end else if (free_found_r) begin
        wr_en  = 1'b1;
        wr_idx = free_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {tag_r, ts_r};
    end
    if (issue) begin
      rd_r <= mem[addr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (state_r == S_EVAL) begin
      if (op_r == OP_START) begin
        if (!found_r && free_found_r) begin
          valid_r[free_idx_r] <= 1'b1;
        end
      end else if (found_r) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (ignore) begin
            state_nxt = S_OUT;
          end else if ((in_tuser == OP_END) && !in_beat.switch_mark) begin
            state_nxt = S_CNT_STS;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit_now || scan_miss) state_nxt = S_EVAL;
      end
      S_EVAL:    state_nxt = S_CNT_CLS;
      S_CNT_CLS: state_nxt = (status_r == ST_STORED) ? S_OUT : S_CNT_STS;
      S_CNT_STS: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      status_r     <= ST_IGNORED;
      addr_r       <= '0;
      q_live_r     <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            addr_r       <= '0;
            q_live_r     <= 1'b0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            if (ignore) begin
              status_r <= ST_IGNORED;
            end else if ((in_tuser == OP_END) && !in_beat.switch_mark) begin
              status_r <= ST_NO_SWITCH;
            end
          end
        end
        S_SCAN: begin
          q_live_r <= issue;
          if (issue) begin
            addr_r <= addr_r + 1'b1;
            if (!valid_r[addr_r[IW-1:0]] && !free_found_r) begin
              free_found_r <= 1'b1;
            end
          end
          if (hit_now) begin
            found_r <= 1'b1;
          end
        end
        S_EVAL: begin
          if (op_r == OP_START) begin
            status_r <= (found_r || free_found_r) ? ST_STORED : ST_FULL;
          end else if (!found_r) begin
            status_r <= ST_MISSING;
          end else if (!alu_rsp.carry) begin
            status_r <= ST_NEGATIVE;
          end else if (!rdy_r) begin
            status_r <= ST_SINK_FULL;
          end else begin
            status_r <= ST_SAMPLE;
          end
        end
        default: ;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      ts_r    <= in_beat.timestamp;
      grp_r   <= in_beat.group_id;
      tag_r   <= in_beat.thread_tag;
      cpu_r   <= in_beat.cpu_id;
      rdy_r   <= in_beat.sink_ready;
      ccnt_r  <= '0;
      scnt_r  <= '0;
    end
    if (issue) begin
      q_vld_r <= valid_r[addr_r[IW-1:0]];
      q_idx_r <= addr_r[IW-1:0];
      if (!valid_r[addr_r[IW-1:0]] && !free_found_r) begin
        free_idx_r <= addr_r[IW-1:0];
      end
    end
    if (hit_now) begin
      hit_idx_r <= q_idx_r;
    end
    if (state_r == S_EVAL) begin
      lat_r   <= alu_rsp.sum;
      start_r <= rd_r[TS_W-1:0];
    end
    if (state_r == S_CNT_CLS) begin
      ccnt_r <= alu_rsp.sum;
    end
    if (state_r == S_CNT_STS) begin
      scnt_r <= alu_rsp.sum;
    end
  end

  // event counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) begin
        cnt_r[k] <= '0;
      end
    end else if ((state_r == S_CNT_CLS) || (state_r == S_CNT_STS)) begin
      cnt_r[cnt_idx] <= alu_rsp.sum;
    end
  end

  // output stage
  assign is_sample = (status_r == ST_SAMPLE);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    out_nxt               = '0;
    out_nxt.class_count   = ccnt_r;
    out_nxt.status_count  = scnt_r;
    if (is_sample) begin
      out_nxt.start_time    = start_r;
      out_nxt.end_time      = ts_r;
      out_nxt.latency       = lat_r;
      out_nxt.sample_group  = grp_r;
      out_nxt.sample_thread = tag_r;
      out_nxt.sample_cpu    = cpu_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r        <= out_nxt;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign out_tuser  = out_status_r;

  `TSSLM_CHECK_IMM(a_hit_valid, (state_r == S_EVAL) && found_r, valid_r[hit_idx_r])
  `TSSLM_CHECK_NXT(a_busy_after_accept, in_acc, !in_tready)
  `TSSLM_CHECK_IMM(a_sample_latency, out_valid_r && (out_status_r == ST_SAMPLE), out_r.latency == (out_r.end_time - out_r.start_time))
  `TSSLM_CHECK_IMM(a_quiet_counts, out_valid_r && ((out_status_r == ST_IGNORED) || (out_status_r == ST_STORED)), out_r.status_count == '0)

endmodule
